FILE: sv/checked_int64_alu_assert.svh
// assertion macros for the checked int64 alu
`ifndef CHECKED_INT64_ALU_ASSERT_SVH
`define CHECKED_INT64_ALU_ASSERT_SVH
// implication checked on every clock edge out of reset
`define CIA_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// next-cycle implication
`define CIA_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

FILE: sv/cia_pkg.sv
// ---------------------------------------------------------------------------
// cia_pkg
// shared types and constants of the checked int64 alu
// ---------------------------------------------------------------------------
`default_nettype none
package cia_pkg;
	localparam int unsigned DataW = 64;
	localparam int unsigned HalfW = 32;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_DIVZERO  = 2'd2,
		ST_UNUSED   = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  op;
		logic signed [63:0] operand_a;
		logic signed [63:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic [1:0]  status;
	} rsp_t;

	// classified work handed from the front part to the back part
	typedef struct packed {
		op_t         op;
		logic        neg;
		logic        early;      // result fully known in front part
		status_t     early_st;
		logic [63:0] early_val;
		logic [63:0] mag_a;
		logic [63:0] mag_b;
	} work_t;
endpackage
`default_nettype wire

FILE: sv/cia_stream_if.sv
// ---------------------------------------------------------------------------
// cia_stream_if
// valid/ready channel carrying one item
// ---------------------------------------------------------------------------
`default_nettype none
interface cia_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/cia_front.sv
// ---------------------------------------------------------------------------
// cia_front
// accepts items, resolves add/sub and error cases, forms magnitudes
// ---------------------------------------------------------------------------
`default_nettype none
module cia_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cia_pkg::req_t in_data,
	input  wire logic          in_valid,
	output logic               in_ready,
	output cia_pkg::work_t     wk_data,
	output logic               wk_valid,
	input  wire logic          wk_ready
);
	import cia_pkg::*;

	work_t       cls;
	logic [63:0] a, b, sum, dif;
	logic        ov;

	assign a   = in_data.operand_a;
	assign b   = in_data.operand_b;
	assign sum = a + b;
	assign dif = a - b;

	always_comb begin
		cls           = '0;
		cls.op        = op_t'(in_data.op);
		cls.neg       = a[63] ^ b[63];
		cls.mag_a     = a[63] ? 64'd0 - a : a;
		cls.mag_b     = b[63] ? 64'd0 - b : b;
		cls.early_st  = ST_OK;
		cls.early_val = '0;
		ov            = 1'b0;
		unique case (op_t'(in_data.op))
			OP_ADD: begin
				ov            = (a[63] == b[63]) && (sum[63] != a[63]);
				cls.early     = 1'b1;
				cls.early_st  = ov ? ST_OVERFLOW : ST_OK;
				cls.early_val = ov ? 64'd0 : sum;
			end
			OP_SUB: begin
				ov            = (a[63] != b[63]) && (dif[63] != a[63]);
				cls.early     = 1'b1;
				cls.early_st  = ov ? ST_OVERFLOW : ST_OK;
				cls.early_val = ov ? 64'd0 : dif;
			end
			OP_MUL: cls.early = 1'b0;
			OP_DIV: begin
				if (b == 64'd0) begin
					cls.early    = 1'b1;
					cls.early_st = ST_DIVZERO;
				end else if (a == {1'b1, 63'd0} && b == '1) begin
					cls.early    = 1'b1;
					cls.early_st = ST_OVERFLOW;
				end
			end
			default: cls.early = 1'b0;
		endcase
	end

	// output register with ready pass-through
	assign in_ready = !wk_valid || wk_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wk_valid <= 1'b0;
		end else if (in_ready) begin
			wk_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			wk_data <= cls;
		end
	end
endmodule
`default_nettype wire

FILE: sv/cia_fifo.sv
// ---------------------------------------------------------------------------
// cia_fifo
// short queue between front and back parts
// ---------------------------------------------------------------------------
`default_nettype none
module cia_fifo #(
	parameter int unsigned Depth = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire cia_pkg::work_t wr_data,
	input  wire logic           wr_valid,
	output logic                wr_ready,
	output cia_pkg::work_t      rd_data,
	output logic                rd_valid,
	input  wire logic           rd_ready
);
	import cia_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

	work_t            mem_q [Depth];
	logic [PtrW-1:0]  wp_q, rp_q;
	logic [PtrW:0]    cnt_q;
	logic             wr_en, rd_en;

	assign wr_ready = cnt_q != (PtrW+1)'(Depth);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rp_q];
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd_en) begin
				rp_q <= (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PtrW+1)'(wr_en) - (PtrW+1)'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
	end
endmodule
`default_nettype wire

FILE: sv/cia_back.sv
// ---------------------------------------------------------------------------
// cia_back
// pipelined multiply and radix-2 divide, one bit per stage
// ---------------------------------------------------------------------------
`default_nettype none
`include "checked_int64_alu_assert.svh"
module cia_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire cia_pkg::work_t wk_data,
	input  wire logic           wk_valid,
	output logic                wk_ready,
	output cia_pkg::rsp_t       out_data,
	output logic                out_valid,
	input  wire logic           out_ready
);
	import cia_pkg::*;

	// stages: 0 partial products, 1 sum, then 64 divide steps, then result
	localparam int unsigned NDiv = DataW;
	localparam int unsigned NStg = NDiv + 2;

	typedef struct packed {
		op_t         op;
		logic        neg;
		logic        early;
		status_t     early_st;
		logic [63:0] early_val;
		logic [63:0] rem;    // divide partial remainder
		logic [63:0] quo;    // dividend shifting out, quotient shifting in
		logic [63:0] dvs;
		logic [127:0] prod;
	} pipe_t;

	pipe_t          st_q [NStg];
	logic [NStg-1:0] vld_q;
	logic           adv;
	logic [63:0]    p0_s1, p1_s1, p2_s1, p3_s1;
	pipe_t          s0_d, s1_d;

	// out register: one slot plus stall of whole pipe when full
	assign adv      = !out_valid || out_ready;
	assign wk_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[NStg-2:0], wk_valid};
			out_valid <= vld_q[NStg-1];
		end
	end

	// stage 0: 32x32 partial products
	always_comb begin
		s0_d           = '0;
		s0_d.op        = wk_data.op;
		s0_d.neg       = wk_data.neg;
		s0_d.early     = wk_data.early;
		s0_d.early_st  = wk_data.early_st;
		s0_d.early_val = wk_data.early_val;
		s0_d.quo       = wk_data.mag_a;
		s0_d.dvs       = wk_data.mag_b;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_q[0] <= s0_d;
			p0_s1 <= wk_data.mag_a[31:0]  * wk_data.mag_b[31:0];
			p1_s1 <= wk_data.mag_a[31:0]  * wk_data.mag_b[63:32];
			p2_s1 <= wk_data.mag_a[63:32] * wk_data.mag_b[31:0];
			p3_s1 <= wk_data.mag_a[63:32] * wk_data.mag_b[63:32];
		end
	end

	// stage 1: sum partial products; divide stages follow
	always_comb begin
		s1_d      = st_q[0];
		s1_d.prod = {p3_s1, p0_s1} + {32'd0, p1_s1, 32'd0}
			+ {32'd0, p2_s1, 32'd0};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_q[1] <= s1_d;
		end
	end

	for (genvar i = 0; i < NDiv; i++) begin : g_div
		logic [64:0] trial;
		logic [64:0] shifted;
		pipe_t       nxt;
		assign shifted = {st_q[i+1].rem, st_q[i+1].quo[63]};
		assign trial   = shifted - {1'b0, st_q[i+1].dvs};
		always_comb begin
			nxt = st_q[i+1];
			if (!trial[64]) begin
				nxt.rem = trial[63:0];
				nxt.quo = {st_q[i+1].quo[62:0], 1'b1};
			end else begin
				nxt.rem = shifted[63:0];
				nxt.quo = {st_q[i+1].quo[62:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				st_q[i+2] <= nxt;
			end
		end
	end

	// final result
	pipe_t       fin;
	rsp_t        res;
	logic [63:0] lo;
	assign fin = st_q[NStg-1];
	assign lo  = fin.prod[63:0];

	always_comb begin
		res.value  = '0;
		res.status = ST_OK;
		if (fin.early) begin
			res.status = fin.early_st;
			res.value  = fin.early_val;
		end else if (fin.op == OP_MUL) begin
			if (fin.prod[127:64] != '0 || (fin.neg ? lo > {1'b1, 63'd0} : lo[63])) begin
				res.status = ST_OVERFLOW;
			end else begin
				res.value = fin.neg ? 64'd0 - lo : lo;
			end
		end else begin
			res.value = fin.neg ? 64'd0 - fin.quo : fin.quo;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_q[NStg-1]) begin
			out_data <= res;
		end
	end

	`CIA_ASSERT_IMP(a_no_code3, clk, arst_n, out_valid, out_data.status != ST_UNUSED)
	`CIA_ASSERT_IMP(a_err_zero, clk, arst_n, out_valid && out_data.status != ST_OK,
		out_data.value == '0)
	`CIA_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_data))
endmodule
`default_nettype wire

FILE: sv/checked_int64_alu.sv
// ---------------------------------------------------------------------------
// checked_int64_alu
// signed 64-bit add/sub/mul/div with overflow and divide-by-zero status
// ---------------------------------------------------------------------------
// One item enters per cycle and one result leaves per cycle when the output
// is taken. Each item passes the front register, then the queue, then the
// back pipeline (two multiply stages, 64 one-bit restoring divide stages,
// one result register), whose length the divide stages set. All ops pass
// through the same pipe, so results keep order.
`default_nettype none
module checked_int64_alu #(
	parameter int unsigned QueueDepth = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cia_stream_if.sink   in_ch,
	cia_stream_if.source out_ch
);
	import cia_pkg::*;

	work_t f_data, q_data;
	logic  f_valid, f_ready, q_valid, q_ready;

	cia_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_data(in_ch.data), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.wk_data(f_data), .wk_valid(f_valid), .wk_ready(f_ready)
	);

	cia_fifo #(.Depth(QueueDepth)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_data(f_data), .wr_valid(f_valid), .wr_ready(f_ready),
		.rd_data(q_data), .rd_valid(q_valid), .rd_ready(q_ready)
	);

	cia_back u_back (
		.clk(clk), .arst_n(arst_n),
		.wk_data(q_data), .wk_valid(q_valid), .wk_ready(q_ready),
		.out_data(out_ch.data), .out_valid(out_ch.valid), .out_ready(out_ch.ready)
	);
endmodule
`default_nettype wire
